>>> hdl/htt_pkg.sv
// shared types, widths and corner tables for the hex to tet splitter
package htt_pkg;

    localparam int NODE_INDEX_BITS = 24;
    localparam int GROUP_BITS      = 16;
    localparam int CORNERS         = 8;
    localparam int TETS_MAX        = 6;
    localparam int FAR_FACE_COUNT  = 3;
    localparam int FACE_CORNERS    = 4;
    localparam int TET_CORNERS     = 4;

    typedef logic [NODE_INDEX_BITS-1:0]              t_node;
    typedef logic [CORNERS-1:0][NODE_INDEX_BITS-1:0] t_hex;
    typedef logic [GROUP_BITS-1:0]                   t_group;
    typedef logic [2:0]                              t_corner;
    typedef logic [1:0]                              t_face_pos;
    typedef logic [2:0]                              t_case;
    typedef logic [2:0]                              t_tet_num;

    localparam t_case    CASE_FIVE_TETS = 3'd0;
    localparam t_tet_num LAST_OF_FIVE   = 3'd4;
    localparam t_tet_num LAST_OF_SIX    = 3'd5;
    localparam t_corner  DIAG_CORNER    = 3'd6;

    // row p maps local corner to original corner when original corner p is the pivot
    localparam t_corner ROT_TABLE [CORNERS][CORNERS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7},
        '{3'd1, 3'd0, 3'd4, 3'd5, 3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd2, 3'd1, 3'd5, 3'd6, 3'd3, 3'd0, 3'd4, 3'd7},
        '{3'd3, 3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd6},
        '{3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6},
        '{3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7},
        '{3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4},
        '{3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5}
    };

    // faces away from the pivot, local numbering
    localparam t_corner FAR_FACES [FAR_FACE_COUNT][FACE_CORNERS] = '{
        '{3'd1, 3'd2, 3'd6, 3'd5},
        '{3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd4, 3'd5, 3'd6, 3'd7}
    };

    // first configuration of each case, local numbering; when no far diagonal
    // touches the far corner only five rows are used
    localparam t_corner TET_TABLE [8][TETS_MAX][TET_CORNERS] = '{
        '{'{3'd0,3'd1,3'd2,3'd5}, '{3'd0,3'd2,3'd7,3'd5}, '{3'd0,3'd2,3'd3,3'd7},
          '{3'd0,3'd5,3'd7,3'd4}, '{3'd2,3'd7,3'd5,3'd6}, '{3'd0,3'd0,3'd0,3'd0}},
        '{'{3'd0,3'd5,3'd7,3'd4}, '{3'd0,3'd7,3'd2,3'd3}, '{3'd0,3'd1,3'd6,3'd5},
          '{3'd0,3'd6,3'd7,3'd5}, '{3'd0,3'd7,3'd6,3'd2}, '{3'd1,3'd0,3'd6,3'd2}},
        '{'{3'd0,3'd5,3'd7,3'd4}, '{3'd0,3'd1,3'd2,3'd5}, '{3'd0,3'd5,3'd6,3'd7},
          '{3'd0,3'd2,3'd6,3'd5}, '{3'd0,3'd6,3'd3,3'd7}, '{3'd0,3'd2,3'd3,3'd6}},
        '{'{3'd0,3'd5,3'd7,3'd4}, '{3'd0,3'd5,3'd6,3'd7}, '{3'd0,3'd6,3'd3,3'd7},
          '{3'd0,3'd1,3'd6,3'd5}, '{3'd0,3'd1,3'd2,3'd6}, '{3'd0,3'd2,3'd3,3'd6}},
        '{'{3'd0,3'd1,3'd2,3'd5}, '{3'd0,3'd2,3'd3,3'd7}, '{3'd0,3'd2,3'd6,3'd5},
          '{3'd0,3'd5,3'd6,3'd4}, '{3'd0,3'd6,3'd7,3'd4}, '{3'd0,3'd6,3'd2,3'd7}},
        '{'{3'd0,3'd2,3'd3,3'd7}, '{3'd0,3'd5,3'd6,3'd4}, '{3'd0,3'd1,3'd2,3'd6},
          '{3'd0,3'd1,3'd6,3'd5}, '{3'd4,3'd7,3'd6,3'd0}, '{3'd0,3'd7,3'd6,3'd2}},
        '{'{3'd0,3'd1,3'd2,3'd5}, '{3'd0,3'd2,3'd6,3'd5}, '{3'd0,3'd6,3'd2,3'd3},
          '{3'd0,3'd6,3'd7,3'd4}, '{3'd0,3'd6,3'd3,3'd7}, '{3'd0,3'd5,3'd6,3'd4}},
        '{'{3'd0,3'd1,3'd6,3'd5}, '{3'd0,3'd6,3'd1,3'd2}, '{3'd0,3'd5,3'd6,3'd4},
          '{3'd0,3'd6,3'd7,3'd4}, '{3'd0,3'd6,3'd2,3'd3}, '{3'd0,3'd6,3'd3,3'd7}}
    };

endpackage

>>> hdl/htt_orient.sv
// pivot search and local renumbering of one hex
module htt_orient
    import htt_pkg::*;
(
    input  t_hex i_node,
    output t_hex o_loc
);

    t_corner pair_win [4];
    t_corner half_win [2];
    t_corner pivot;

    // the lower-numbered corner of each pair wins ties so the earliest corner is kept
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pair_win[i] = (i_node[2*i+1] < i_node[2*i]) ? t_corner'(2*i+1) : t_corner'(2*i);
        end
        for (int i = 0; i < 2; i++) begin
            half_win[i] = (i_node[pair_win[2*i+1]] < i_node[pair_win[2*i]]) ?
                          pair_win[2*i+1] : pair_win[2*i];
        end
        pivot = (i_node[half_win[1]] < i_node[half_win[0]]) ? half_win[1] : half_win[0];
        for (int l = 0; l < CORNERS; l++) begin
            o_loc[l] = i_node[ROT_TABLE[pivot][l]];
        end
    end

endmodule

>>> hdl/htt_emit.sv
// holds one classified hex; its tets go out via a register, one per cycle unless stalled
module htt_emit
    import htt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_hex_valid,
    output logic     o_hex_ready,
    input  t_hex     i_loc,
    input  t_group   i_group,
    input  t_case    i_case,
    output logic     o_valid,
    input  logic     i_ready,
    output t_node    o_tet_a,
    output t_node    o_tet_b,
    output t_node    o_tet_c,
    output t_node    o_tet_d,
    output t_group   o_group_out,
    output t_tet_num o_tet_number,
    output t_case    o_split_case,
    output logic     o_last_tet
);

    logic     r_vld;
    t_hex     r_loc;
    t_group   r_group;
    t_case    r_case;
    t_tet_num r_cnt;
    t_tet_num n_cnt;

    logic     r_out_vld;
    t_node    r_tet [TET_CORNERS];
    t_group   r_out_group;
    t_tet_num r_out_num;
    t_case    r_out_case;
    logic     r_out_last;

    logic     out_free;
    logic     emit;
    logic     last;
    logic     hex_load;

    assign out_free    = !r_out_vld || i_ready;
    assign emit        = r_vld && out_free;
    assign last        = (r_cnt == ((r_case == CASE_FIVE_TETS) ? LAST_OF_FIVE : LAST_OF_SIX));
    assign o_hex_ready = !r_vld || (emit && last);
    assign hex_load    = i_hex_valid && o_hex_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (hex_load) begin
            n_cnt = '0;
        end else if (emit) begin
            n_cnt = r_cnt + t_tet_num'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (o_hex_ready) begin
                r_vld <= i_hex_valid;
            end
            if (out_free) begin
                r_out_vld <= r_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hex_load) begin
            r_loc   <= i_loc;
            r_group <= i_group;
            r_case  <= i_case;
        end
        if (emit) begin
            for (int k = 0; k < TET_CORNERS; k++) begin
                r_tet[k] <= r_loc[TET_TABLE[r_case][r_cnt][k]];
            end
            r_out_group <= r_group;
            r_out_num   <= r_cnt;
            r_out_case  <= r_case;
            r_out_last  <= last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_tet_a      = r_tet[0];
    assign o_tet_b      = r_tet[1];
    assign o_tet_c      = r_tet[2];
    assign o_tet_d      = r_tet[3];
    assign o_group_out  = r_out_group;
    assign o_tet_number = r_out_num;
    assign o_split_case = r_out_case;
    assign o_last_tet   = r_out_last;

endmodule

>>> hdl/hex_to_tet_splitter_core.sv
// top level: hex input register, pivot and rotation, diagonal case, tet emitter
//
//  channel   direction  handshake           payload
//  hex in    input      i_valid / o_ready   i_corner_0..7, i_group_in
//  tet out   output     o_valid / i_ready   o_tet_a..d, o_group_out, o_tet_number,
//                                           o_split_case, o_last_tet
//
// a taken hex passes the input, rotation and emitter hex registers before its first tet
// reaches the output register, then one tet per cycle while i_ready allows; a hex yields five
// tets when no far diagonal touches the far corner, six otherwise, which sets the hex rate
// the next hex is taken while the previous one is still emitting, so hexes follow
// with no gap cycles on the output
// reset (synchronous, active low) clears all valid flags; payload is not reset
// a low i_ready holds the output register and backs up the stages behind it
module hex_to_tet_splitter_core
    import htt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_node    i_corner_0,
    input  t_node    i_corner_1,
    input  t_node    i_corner_2,
    input  t_node    i_corner_3,
    input  t_node    i_corner_4,
    input  t_node    i_corner_5,
    input  t_node    i_corner_6,
    input  t_node    i_corner_7,
    input  t_group   i_group_in,
    output logic     o_valid,
    input  logic     i_ready,
    output t_node    o_tet_a,
    output t_node    o_tet_b,
    output t_node    o_tet_c,
    output t_node    o_tet_d,
    output t_group   o_group_out,
    output t_tet_num o_tet_number,
    output t_case    o_split_case,
    output logic     o_last_tet
);

    logic      r_a_vld;
    t_hex      r_a_node;
    t_group    r_a_group;
    logic      r_b_vld;
    t_hex      r_b_loc;
    t_group    r_b_group;

    t_hex      a_loc;
    logic      b_free;
    logic      c_ready;
    t_case     b_case;
    t_face_pos lo_a [FAR_FACE_COUNT];
    t_face_pos lo_b [FAR_FACE_COUNT];
    t_face_pos lo   [FAR_FACE_COUNT];
    t_face_pos opp  [FAR_FACE_COUNT];

    assign b_free  = !r_b_vld || c_ready;
    assign o_ready = !r_a_vld || b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_a_vld <= i_valid;
            end
            if (b_free) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_a_node  <= {i_corner_7, i_corner_6, i_corner_5, i_corner_4,
                          i_corner_3, i_corner_2, i_corner_1, i_corner_0};
            r_a_group <= i_group_in;
        end
        if (r_a_vld && b_free) begin
            r_b_loc   <= a_loc;
            r_b_group <= r_a_group;
        end
    end

    htt_orient u_orient (
        .i_node (r_a_node),
        .o_loc  (a_loc)
    );

    // lowest corner of each far face, earliest on ties; its diagonal runs to the opposite corner
    always_comb begin
        for (int f = 0; f < FAR_FACE_COUNT; f++) begin
            lo_a[f] = (r_b_loc[FAR_FACES[f][1]] < r_b_loc[FAR_FACES[f][0]]) ? 2'd1 : 2'd0;
            lo_b[f] = (r_b_loc[FAR_FACES[f][3]] < r_b_loc[FAR_FACES[f][2]]) ? 2'd3 : 2'd2;
            lo[f]   = (r_b_loc[FAR_FACES[f][lo_b[f]]] < r_b_loc[FAR_FACES[f][lo_a[f]]]) ?
                      lo_b[f] : lo_a[f];
            opp[f]  = lo[f] + 2'd2;
            b_case[f] = (FAR_FACES[f][lo[f]] == DIAG_CORNER) ||
                        (FAR_FACES[f][opp[f]] == DIAG_CORNER);
        end
    end

    htt_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hex_valid  (r_b_vld),
        .o_hex_ready  (c_ready),
        .i_loc        (r_b_loc),
        .i_group      (r_b_group),
        .i_case       (b_case),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tet_a      (o_tet_a),
        .o_tet_b      (o_tet_b),
        .o_tet_c      (o_tet_c),
        .o_tet_d      (o_tet_d),
        .o_group_out  (o_group_out),
        .o_tet_number (o_tet_number),
        .o_split_case (o_split_case),
        .o_last_tet   (o_last_tet)
    );

endmodule

>>> hdl/htt_checker.sv
// port-level checks on the splitter output stream, bound to the top level
module htt_checker
    import htt_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_valid,
    input logic     i_ready,
    input t_node    o_tet_a,
    input t_group   o_group_out,
    input t_tet_num o_tet_number,
    input t_case    o_split_case,
    input logic     o_last_tet
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tet_a) && $stable(o_tet_number)
                                && $stable(o_group_out))
        else $error("output changed while stalled");

    // run length follows the case: five tets when no far diagonal touches the far corner
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_tet |->
            o_tet_number == ((o_split_case == CASE_FIVE_TETS) ? LAST_OF_FIVE : LAST_OF_SIX))
        else $error("last tet at wrong position");

    a_not_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_tet |->
            o_tet_number < ((o_split_case == CASE_FIVE_TETS) ? LAST_OF_FIVE : LAST_OF_SIX))
        else $error("tet number past end of run");

    // if valid stays up, a taken non-final tet steps the number and keeps the case
    a_number_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_tet ##1 o_valid |->
            o_tet_number == $past(o_tet_number) + t_tet_num'(1)
            && o_split_case == $past(o_split_case))
        else $error("tet run broken");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind hex_to_tet_splitter_core htt_checker u_htt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_tet_a      (o_tet_a),
    .o_group_out  (o_group_out),
    .o_tet_number (o_tet_number),
    .o_split_case (o_split_case),
    .o_last_tet   (o_last_tet)
);

>>> test/tb_hex_to_tet_splitter_core.sv
// testbench for the hex to tet splitter: directed table and random hexes against a tet predictor
module tb_hex_to_tet_splitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import htt_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_HEXES     = 158;
    localparam int IDLE_PCT         = 34;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int REPORT_MAX       = 10;
    localparam int HOLD_START       = 250;
    localparam int HOLD_CYCLES      = 80;
    localparam int STEADY_RX_START  = 500;
    localparam int STEADY_RX_CYCLES = 300;
    localparam int STEADY_TX_FIRST  = 80;
    localparam int STEADY_TX_LAST   = 130;
    localparam int DIR_ROWS         = 22;
    localparam int FAR_CORNER       = 6;
    localparam t_node TOP           = '1;

    // row p: local corner -> original corner when original corner p holds the lowest index
    localparam int PIVOT_ROT [8][8] = '{
        '{0, 1, 2, 3, 4, 5, 6, 7},
        '{1, 0, 4, 5, 2, 3, 7, 6},
        '{2, 1, 5, 6, 3, 0, 4, 7},
        '{3, 0, 1, 2, 7, 4, 5, 6},
        '{4, 0, 3, 7, 5, 1, 2, 6},
        '{5, 1, 0, 4, 6, 2, 3, 7},
        '{6, 2, 1, 5, 7, 3, 0, 4},
        '{7, 3, 2, 6, 4, 0, 1, 5}
    };

    localparam int FAR_FACE [3][4] = '{
        '{1, 2, 6, 5},
        '{2, 3, 7, 6},
        '{4, 5, 6, 7}
    };

    localparam int SPLIT_ROWS [8][6][4] = '{
        '{'{0,1,2,5}, '{0,2,7,5}, '{0,2,3,7}, '{0,5,7,4}, '{2,7,5,6}, '{0,0,0,0}},
        '{'{0,5,7,4}, '{0,7,2,3}, '{0,1,6,5}, '{0,6,7,5}, '{0,7,6,2}, '{1,0,6,2}},
        '{'{0,5,7,4}, '{0,1,2,5}, '{0,5,6,7}, '{0,2,6,5}, '{0,6,3,7}, '{0,2,3,6}},
        '{'{0,5,7,4}, '{0,5,6,7}, '{0,6,3,7}, '{0,1,6,5}, '{0,1,2,6}, '{0,2,3,6}},
        '{'{0,1,2,5}, '{0,2,3,7}, '{0,2,6,5}, '{0,5,6,4}, '{0,6,7,4}, '{0,6,2,7}},
        '{'{0,2,3,7}, '{0,5,6,4}, '{0,1,2,6}, '{0,1,6,5}, '{4,7,6,0}, '{0,7,6,2}},
        '{'{0,1,2,5}, '{0,2,6,5}, '{0,6,2,3}, '{0,6,7,4}, '{0,6,3,7}, '{0,5,6,4}},
        '{'{0,1,6,5}, '{0,6,1,2}, '{0,5,6,4}, '{0,6,7,4}, '{0,6,2,3}, '{0,6,3,7}}
    };

    typedef struct packed {
        t_node    a;
        t_node    b;
        t_node    c;
        t_node    d;
        t_group   grp;
        t_tet_num num;
        t_case    scase;
        logic     last;
    } t_tet;

    typedef struct {
        t_node  corner [8];
        t_group grp;
        bit     typed;
        t_case  tcase;
    } t_hex_row;

    logic     i_clk      = 1'b0;
    logic     i_rst_n    = 1'b0;
    logic     i_valid    = 1'b0;
    logic     o_ready;
    t_node    i_corner_0 = '0;
    t_node    i_corner_1 = '0;
    t_node    i_corner_2 = '0;
    t_node    i_corner_3 = '0;
    t_node    i_corner_4 = '0;
    t_node    i_corner_5 = '0;
    t_node    i_corner_6 = '0;
    t_node    i_corner_7 = '0;
    t_group   i_group_in = '0;
    logic     o_valid;
    logic     i_ready    = 1'b0;
    t_node    o_tet_a;
    t_node    o_tet_b;
    t_node    o_tet_c;
    t_node    o_tet_d;
    t_group   o_group_out;
    t_tet_num o_tet_number;
    t_case    o_split_case;
    logic     o_last_tet;

    t_tet tets_due [$];
    int   bad_count = 0;

    // typed rows have every corner equal: all ties resolve to the first corner, case 5
    t_hex_row dir_rows [DIR_ROWS] = '{
        '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
          16'h0000, 1'b1, 3'd5},
        '{'{TOP, TOP, TOP, TOP, TOP, TOP, TOP, TOP},
          16'hFFFF, 1'b1, 3'd5},
        // pivot on corner 0, one row per diagonal case 0..7
        '{'{24'd0, 24'd10, 24'd1, 24'd11, 24'd12, 24'd2, 24'd13, 24'd3},
          16'h0001, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd1, 24'd10, 24'd11, 24'd12, 24'd13, 24'd14, 24'd2},
          16'h0002, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd10, 24'd11, 24'd1, 24'd12, 24'd2, 24'd13, 24'd14},
          16'h0003, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd1, 24'd10, 24'd2, 24'd11, 24'd3, 24'd12, 24'd13},
          16'h0004, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd10, 24'd2, 24'd11, 24'd1, 24'd12, 24'd13, 24'd14},
          16'h0005, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd1, 24'd3, 24'd10, 24'd2, 24'd11, 24'd12, 24'd13},
          16'h0006, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd10, 24'd11, 24'd1, 24'd2, 24'd3, 24'd12, 24'd13},
          16'h0007, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, 24'd10, 24'd11, 24'd12, 24'd13, 24'd14, 24'd1, 24'd15},
          16'h0008, 1'b0, CASE_FIVE_TETS},
        // pivot walks through corners 1..7
        '{'{24'd7, 24'd0, 24'd6, 24'd5, 24'd4, 24'd3, 24'd2, 24'd1},
          16'h0011, 1'b0, CASE_FIVE_TETS},
        '{'{24'd100, 24'd200, 24'd0, 24'd300, 24'd50, 24'd60, 24'd70, 24'd80},
          16'h0022, 1'b0, CASE_FIVE_TETS},
        '{'{24'd8, 24'd9, 24'd10, 24'd0, 24'd1, 24'd2, 24'd3, 24'd4},
          16'h0033, 1'b0, CASE_FIVE_TETS},
        '{'{24'd40, 24'd30, 24'd20, 24'd10, 24'd0, 24'd5, 24'd15, 24'd25},
          16'h0044, 1'b0, CASE_FIVE_TETS},
        '{'{24'd123456, 24'd654321, 24'd111111, 24'd222222,
            24'd333333, 24'd0, 24'd444444, 24'd555555},
          16'h0055, 1'b0, CASE_FIVE_TETS},
        '{'{24'd500, 24'd400, 24'd300, 24'd200, 24'd100, 24'd50, 24'd0, 24'd25},
          16'h0066, 1'b0, CASE_FIVE_TETS},
        '{'{24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFD, 24'hFFFFFC,
            24'hFFFFFB, 24'hFFFFFA, 24'hFFFFF9, 24'hFFFFF8},
          16'h0077, 1'b0, CASE_FIVE_TETS},
        // tied lowest index: the earliest corner wins the pivot
        '{'{24'd5, 24'd5, 24'd3, 24'd2, 24'd9, 24'd2, 24'd7, 24'd2},
          16'h8000, 1'b0, CASE_FIVE_TETS},
        // ties on every far face
        '{'{24'd0, 24'd4, 24'd4, 24'd4, 24'd4, 24'd4, 24'd4, 24'd4},
          16'h7FFF, 1'b0, CASE_FIVE_TETS},
        '{'{24'd0, TOP, 24'd0, TOP, TOP, 24'd0, TOP, 24'd0},
          16'hAAAA, 1'b0, CASE_FIVE_TETS},
        '{'{TOP, 24'd0, TOP, 24'd0, 24'd0, TOP, 24'd0, TOP},
          16'h5555, 1'b0, CASE_FIVE_TETS},
        '{'{TOP, TOP, TOP, TOP, TOP, TOP, 24'd0, TOP},
          16'hFFFF, 1'b0, CASE_FIVE_TETS}
    };

    hex_to_tet_splitter_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_corner_0   (i_corner_0),
        .i_corner_1   (i_corner_1),
        .i_corner_2   (i_corner_2),
        .i_corner_3   (i_corner_3),
        .i_corner_4   (i_corner_4),
        .i_corner_5   (i_corner_5),
        .i_corner_6   (i_corner_6),
        .i_corner_7   (i_corner_7),
        .i_group_in   (i_group_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_tet_a      (o_tet_a),
        .o_tet_b      (o_tet_b),
        .o_tet_c      (o_tet_c),
        .o_tet_d      (o_tet_d),
        .o_group_out  (o_group_out),
        .o_tet_number (o_tet_number),
        .o_split_case (o_split_case),
        .o_last_tet   (o_last_tet)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // lowest-vertex split of one hex, queued in emission order
    function automatic void split_hex(input t_node c [8], input t_group g);
        int    rot [8];
        int    pv;
        int    lo;
        int    n;
        t_case sc;
        t_tet  t;
        pv = 0;
        for (int j = 1; j < 8; j++)
            if (c[j] < c[pv]) pv = j;
        for (int j = 0; j < 8; j++)
            rot[j] = PIVOT_ROT[pv][j];
        sc = '0;
        for (int f = 0; f < 3; f++) begin
            lo = 0;
            for (int k = 1; k < 4; k++)
                if (c[rot[FAR_FACE[f][k]]] < c[rot[FAR_FACE[f][lo]]]) lo = k;
            if (FAR_FACE[f][lo] == FAR_CORNER || FAR_FACE[f][(lo + 2) % 4] == FAR_CORNER)
                sc[f] = 1'b1;
        end
        n = (sc == CASE_FIVE_TETS) ? TETS_MAX - 1 : TETS_MAX;
        for (int j = 0; j < n; j++) begin
            t.a     = c[rot[SPLIT_ROWS[sc][j][0]]];
            t.b     = c[rot[SPLIT_ROWS[sc][j][1]]];
            t.c     = c[rot[SPLIT_ROWS[sc][j][2]]];
            t.d     = c[rot[SPLIT_ROWS[sc][j][3]]];
            t.grp   = g;
            t.num   = t_tet_num'(j);
            t.scase = sc;
            t.last  = (j == n - 1);
            tets_due.push_back(t);
        end
    endfunction

    // called and returns at a falling edge; valid stays up for a back-to-back request
    task automatic offer_hex(input t_node c [8], input t_group g, input bit typed,
                             input t_case tcase, input bit steady);
        int   gap;
        int   n;
        t_tet t;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_corner_0 = c[0];
        i_corner_1 = c[1];
        i_corner_2 = c[2];
        i_corner_3 = c[3];
        i_corner_4 = c[4];
        i_corner_5 = c[5];
        i_corner_6 = c[6];
        i_corner_7 = c[7];
        i_group_in = g;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (typed) begin
            n = (tcase == CASE_FIVE_TETS) ? TETS_MAX - 1 : TETS_MAX;
            for (int j = 0; j < n; j++) begin
                t = '{c[0], c[0], c[0], c[0], g, t_tet_num'(j), tcase, j == n - 1};
                tets_due.push_back(t);
            end
        end else begin
            split_hex(c, g);
        end
        @(negedge i_clk);
    endtask

    initial begin : hex_source
        t_node  c [8];
        t_node  base;
        t_node  swap;
        t_group g;
        int     kind;
        int     s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        for (int r = 0; r < DIR_ROWS; r++)
            offer_hex(dir_rows[r].corner, dir_rows[r].grp, dir_rows[r].typed,
                      dir_rows[r].tcase, 1'b0);
        for (int h = 0; h < RANDOM_HEXES; h++) begin
            kind = $urandom_range(9);
            g    = t_group'($urandom);
            case (kind)
                5, 6: begin
                    // tiny index range: ties everywhere
                    for (int k = 0; k < 8; k++) c[k] = t_node'($urandom_range(3));
                end
                7: begin
                    base = t_node'($urandom_range(24'hFFFFF0));
                    for (int k = 0; k < 8; k++) c[k] = base + t_node'(k);
                    for (int k = 7; k > 0; k--) begin
                        s    = $urandom_range(k);
                        swap = c[k];
                        c[k] = c[s];
                        c[s] = swap;
                    end
                end
                8: begin
                    for (int k = 0; k < 8; k++) begin
                        s = $urandom_range(2);
                        if (s == 0)      c[k] = '0;
                        else if (s == 1) c[k] = TOP;
                        else             c[k] = t_node'($urandom) | 24'hFFFF00;
                    end
                end
                9: begin
                    base = t_node'($urandom);
                    for (int k = 0; k < 8; k++) c[k] = base;
                end
                default: begin
                    for (int k = 0; k < 8; k++) c[k] = t_node'($urandom);
                end
            endcase
            offer_hex(c, g, 1'b0, CASE_FIVE_TETS,
                      h >= STEADY_TX_FIRST && h < STEADY_TX_LAST);
        end
        i_valid = 1'b0;
        while (tets_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (bad_count == 0 && tets_due.size() == 0) begin
            $display("hex_to_tet_splitter_core test passed");
        end else begin
            $display("hex_to_tet_splitter_core test failed");
        end
        $finish;
    end

    // random ready, one steady window and one long hold-off to fill the splitter and push back
    initial begin : tet_sink
        int cyc;
        cyc = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES)
                i_ready = 1'b0;
            else if (cyc >= STEADY_RX_START && cyc < STEADY_RX_START + STEADY_RX_CYCLES)
                i_ready = 1'b1;
            else
                i_ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_tet got;
        t_tet want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_tet_a, o_tet_b, o_tet_c, o_tet_d, o_group_out,
                    o_tet_number, o_split_case, o_last_tet};
            if (tets_due.size() == 0) begin
                if (bad_count < REPORT_MAX)
                    $display("unexpected tet at %0t: a=%h b=%h c=%h d=%h grp=%h num=%0d case=%0d last=%b",
                             $realtime, got.a, got.b, got.c, got.d, got.grp, got.num,
                             got.scase, got.last);
                bad_count++;
            end else begin
                want = tets_due.pop_front();
                if (got != want) begin
                    if (bad_count < REPORT_MAX) begin
                        $display("tet mismatch at %0t", $realtime);
                        $display("  exp a=%h b=%h c=%h d=%h grp=%h num=%0d case=%0d last=%b",
                                 want.a, want.b, want.c, want.d, want.grp, want.num,
                                 want.scase, want.last);
                        $display("  got a=%h b=%h c=%h d=%h grp=%h num=%0d case=%0d last=%b",
                                 got.a, got.b, got.c, got.d, got.grp, got.num,
                                 got.scase, got.last);
                    end
                    bad_count++;
                end
            end
        end
    end

    // ends the run when neither channel moves for too long
    initial begin : watchdog
        int stalled;
        stalled = 0;
        @(posedge i_rst_n);
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stalled = 0;
            else stalled++;
        end
        $display("hex_to_tet_splitter_core test failed");
        $finish;
    end

endmodule
